// File: src/gim_pkg.sv
// Shared types and constants for the GF(2^m) extended Euclidean inverter.
// Holds the controller/datapath command and status structs and the reset modulus.
// No dependencies.
package gim_pkg;

   // Reset modulus x^10+x^3+1, wide enough to slice at any field width up to 63 bits
   localparam logic [63:0] DEFAULT_MODULUS = 64'd1033;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic reduce;
      logic swap;
      logic capture;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rb_zero;
      logic reducible;
   } dp_sts_type;

endpackage

// File: src/gim_dp.sv
// Datapath of the inverter: remainder pair, coefficient pair and result register.
// One shift-xor reduction or one swap per cycle under controller command.
// Depends on gim_pkg.
module gim_dp
   import gim_pkg::*;
#(
   parameter int FIELD_BITS = 10
) (
   input  logic                  clock,
   input  logic [FIELD_BITS:0]   modulus,
   input  logic [FIELD_BITS-1:0] value,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   output logic [FIELD_BITS-1:0] inverse,
   output logic                  has_inverse
);

   localparam int LW = $clog2(FIELD_BITS + 2);

   logic [FIELD_BITS:0]   ra_ff, ra_in;
   logic [FIELD_BITS:0]   rb_ff, rb_in;
   logic [FIELD_BITS-1:0] ca_ff, ca_in;
   logic [FIELD_BITS-1:0] cb_ff, cb_in;
   logic [FIELD_BITS-1:0] inverse_ff;
   logic                  has_inverse_ff;
   logic [LW-1:0]         len_ra;
   logic [LW-1:0]         len_rb;
   logic [LW-1:0]         shift;
   logic                  ra_one;

   // Number of significant bits of a polynomial
   function automatic logic [LW-1:0] poly_len(input logic [FIELD_BITS:0] p);
      logic [LW-1:0] n;
      n = '0;
      for (int i = 0; i <= FIELD_BITS; i++) begin
         if (p[i]) begin
            n = LW'(i + 1);
         end
      end
      return n;
   endfunction

   // Degree compare and alignment shift
   assign len_ra = poly_len(ra_ff);
   assign len_rb = poly_len(rb_ff);
   assign shift  = len_ra - len_rb;
   assign ra_one = (ra_ff == (FIELD_BITS + 1)'(1));

   assign sts.rb_zero   = (rb_ff == '0);
   assign sts.reducible = (ra_ff != '0) && (len_ra >= len_rb);

   // Next values of the remainder and coefficient pairs
   always_comb begin
      ra_in = ra_ff;
      rb_in = rb_ff;
      ca_in = ca_ff;
      cb_in = cb_ff;
      if (cmd.load) begin
         ra_in = modulus;
         rb_in = {1'b0, value};
         ca_in = '0;
         cb_in = FIELD_BITS'(1);
      end else if (cmd.reduce) begin
         ra_in = ra_ff ^ (rb_ff << shift);
         ca_in = ca_ff ^ (cb_ff << shift);
      end else if (cmd.swap) begin
         ra_in = rb_ff;
         rb_in = ra_ff;
         ca_in = cb_ff;
         cb_in = ca_ff;
      end
   end

   // Hold working registers
   always_ff @(posedge clock) begin
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      ca_ff <= ca_in;
      cb_ff <= cb_in;
   end

   // Capture the result once the remainder chain ends
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         inverse_ff     <= ra_one ? ca_ff : '0;
         has_inverse_ff <= ra_one;
      end
   end

   assign inverse     = inverse_ff;
   assign has_inverse = has_inverse_ff;

endmodule

// File: src/gim_ctrl.sv
// Controller of the inverter: sequences load, reduce/swap steps and result capture,
// and owns the request and response handshakes. Depends on gim_pkg.
module gim_ctrl
   import gim_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // Decode commands from state and datapath status
   always_comb begin
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
         end
         ST_RUN: begin
            if (sts.rb_zero) begin
               cmd.capture = !rsp_valid_ff || rsp_tready;
            end else if (sts.reducible) begin
               cmd.reduce = 1'b1;
            end else begin
               cmd.swap = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Advance state and hold the response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (cmd.capture) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (cmd.capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: src/gf2m_inverse_ext_euclid_unit.sv
// Top level of the GF(2^m) inverter: modulus register, controller and datapath.
// Depends on gim_pkg, gim_ctrl and gim_dp.
//
// Usage:
//   A request on req_ carries one field element; one response on rsp_ carries
//   its inverse modulo the polynomial held in the modulus register, and a flag
//   that is 1 when the gcd with the modulus is 1 (inverse 0 and flag 0 otherwise).
//   The modulus is written through csr_wr_en / csr_wr_data. The user must write
//   it only while the block idles; the block itself does not enforce this.
//   The accepting edge loads the datapath, then each cycle does one shift-xor
//   reduction or one remainder swap, then the result is captured once the
//   remainder rb reaches zero and the response register is free. With k
//   division rounds (k <= FIELD_BITS) an element needs at most FIELD_BITS+k
//   reductions and k swaps. One request is worked on at a time; the next is
//   taken the cycle after capture.
//   The response sits in an output register: a new request is taken while it
//   waits. If the receiver stalls and the next inversion finishes, the block
//   holds that result inside until the response register frees up.
//   Reset empties the response register, returns to idle and loads the
//   modulus x^10+x^3+1 (truncated to FIELD_BITS+1 bits).
module gf2m_inverse_ext_euclid_unit
   import gim_pkg::*;
#(
   parameter int FIELD_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request: [FIELD_BITS-1:0] value, zero padded
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((FIELD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Response: [FIELD_BITS-1:0] inverse, [FIELD_BITS] has_inverse, zero padded
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((FIELD_BITS + 8) / 8) * 8 - 1:0] rsp_tdata,
   // Modulus register write
   input  logic                                   csr_wr_en,
   input  logic [FIELD_BITS:0]                    csr_wr_data
);

   localparam int RSP_W = ((FIELD_BITS + 8) / 8) * 8;

   logic [FIELD_BITS:0]   modulus_ff;
   logic [FIELD_BITS-1:0] inverse;
   logic                  has_inverse;
   dp_cmd_type            cmd;
   dp_sts_type            sts;

   // Hold the modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= DEFAULT_MODULUS[FIELD_BITS:0];
      end else if (csr_wr_en) begin
         modulus_ff <= csr_wr_data;
      end
   end

   gim_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gim_dp #(
      .FIELD_BITS (FIELD_BITS)
   ) u_dp (
      .clock       (clock),
      .modulus     (modulus_ff),
      .value       (req_tdata[FIELD_BITS-1:0]),
      .cmd         (cmd),
      .sts         (sts),
      .inverse     (inverse),
      .has_inverse (has_inverse)
   );

   // Pack the response
   assign rsp_tdata = RSP_W'({has_inverse, inverse});

   // A missing inverse always reads as zero
   a_no_inv_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !has_inverse |-> inverse == '0)
      else $error("inverse nonzero without has_inverse");

   // An accepted request makes the block busy
   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted but block not busy");

   // A new response only appears out of a running inversion
   a_rsp_from_run : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised while idle");

   // Load, reduce, swap and capture are mutually exclusive
   a_cmd_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.reduce, cmd.swap, cmd.capture}))
      else $error("conflicting datapath commands");

endmodule

// File: sim/gim_inverse_checker.sv
`timescale 1ns / 1ps
// Response checker for the GF(2^m) inverter: watches the request, response and
// modulus write ports, predicts each inverse and compares it field by field.
// Depends on gim_pkg for the reset modulus.
module gim_inverse_checker
   import gim_pkg::*;
#(
   parameter int FIELD_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request: [FIELD_BITS-1:0] value, zero padded
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   input  logic [((FIELD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Response: [FIELD_BITS-1:0] inverse, [FIELD_BITS] has_inverse, zero padded
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [((FIELD_BITS + 8) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                   csr_wr_en,
   input  logic [FIELD_BITS:0]                    csr_wr_data,
   output int                                     fail_count,
   output int                                     pending_count,
   output int                                     inverted_count,
   output int                                     invertible_count
);

   typedef struct packed {
      logic                  has_inverse;
      logic [FIELD_BITS-1:0] inverse;
   } inverse_result_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] operand;
      inverse_result_type    result;
   } inverse_record_type;

   logic [FIELD_BITS:0] modulus;
   inverse_record_type  awaited_inverses[$];

   // Number of significant bits of a binary polynomial
   function automatic int poly_len(input logic [63:0] poly);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++)
         if (poly[i]) n = i + 1;
      return n;
   endfunction

   // Extended Euclid over GF(2)[x]: remainder chain plus the track of the
   // coefficient that multiplies the operand
   function automatic inverse_result_type predict_inverse(
      input logic [FIELD_BITS:0]   poly_mod,
      input logic [FIELD_BITS-1:0] operand);
      logic [63:0]        ra, rb, ca, cb, quo, rest, prod;
      int                 num_len, den_len;
      inverse_result_type res;
      ra = 64'(poly_mod);
      rb = 64'(operand);
      ca = '0;
      cb = 64'd1;
      while (rb != '0) begin
         // carry-less long division of ra by rb
         quo = '0;
         rest = ra;
         num_len = poly_len(rest);
         den_len = poly_len(rb);
         while (num_len >= den_len && rest != '0) begin
            quo ^= 64'd1 << (num_len - den_len);
            rest ^= rb << (num_len - den_len);
            num_len = poly_len(rest);
         end
         // carry-less product of quotient and coefficient
         prod = '0;
         for (int i = 0; i < 64; i++)
            if (quo[i]) prod ^= cb << i;
         ra = rb;
         rb = rest;
         prod = ca ^ prod;
         ca = cb;
         cb = prod;
      end
      res = '0;
      if (ra == 64'd1) begin
         res.has_inverse = 1'b1;
         res.inverse = ca[FIELD_BITS-1:0];
      end
      return res;
   endfunction

   // Count a failure, report only the first few
   task automatic note_failure(input string what, input inverse_record_type want,
                               input inverse_result_type seen);
      if (fail_count < 10)
         $display("%0t mismatch (%s): value %h expected inverse %h flag %b, %s %h flag %b",
                  $realtime, what, want.operand, want.result.inverse,
                  want.result.has_inverse, "got inverse", seen.inverse, seen.has_inverse);
      fail_count <= fail_count + 1;
   endtask

   // Track the modulus, queue predictions per request, compare per response
   always @(posedge clock) begin : watch
      inverse_record_type want;
      inverse_result_type seen;
      if (reset) begin
         modulus <= DEFAULT_MODULUS[FIELD_BITS:0];
         awaited_inverses.delete();
         pending_count <= 0;
      end else begin
         if (csr_wr_en) modulus <= csr_wr_data;
         if (req_tvalid && req_tready) begin
            want.operand = req_tdata[FIELD_BITS-1:0];
            want.result = predict_inverse(modulus, want.operand);
            awaited_inverses.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[FIELD_BITS:0];
            if (awaited_inverses.size() == 0) begin
               want = '0;
               note_failure("unexpected response", want, seen);
            end else begin
               want = awaited_inverses.pop_front();
               inverted_count <= inverted_count + 1;
               if (want.result.has_inverse) invertible_count <= invertible_count + 1;
               if (seen.has_inverse !== want.result.has_inverse)
                  note_failure("has_inverse", want, seen);
               else if (seen.inverse !== want.result.inverse)
                  note_failure("inverse", want, seen);
            end
         end
         pending_count <= awaited_inverses.size();
      end
   end

endmodule

// File: sim/tb_gf2m_inverse_ext_euclid_unit.sv
`timescale 1ns / 1ps
// Testbench top for gf2m_inverse_ext_euclid_unit: clock, reset, modulus writes,
// request stimulus, response back-pressure, watchdog and verdict.
// Depends on the unit under test and gim_inverse_checker.
module tb_gf2m_inverse_ext_euclid_unit;

   localparam int FIELD_BITS   = 10;
   localparam int REQ_W        = ((FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_W        = ((FIELD_BITS + 8) / 8) * 8;
   localparam int N_MODULI     = 12;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 2 * FIELD_BITS + 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;   // [FIELD_BITS-1:0] value
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;        // [FIELD_BITS-1:0] inverse, [FIELD_BITS] has_inverse
   logic                csr_wr_en = 1'b0;
   logic [FIELD_BITS:0] csr_wr_data = '0;

   logic calm = 1'b0;
   int   rsp_hold = 0;
   int   quiet_cycles = 0;
   int   fail_count, pending_count, inverted_count, invertible_count;

   always #5 clock = ~clock;

   gf2m_inverse_ext_euclid_unit #(.FIELD_BITS(FIELD_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   gim_inverse_checker #(.FIELD_BITS(FIELD_BITS)) inverse_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .inverted_count   (inverted_count),
      .invertible_count (invertible_count)
   );

   // Stall the response side in random bursts, except in the calm phase
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= int'($urandom_range(0, 10));
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request, with an optional idle gap before it; return at its handshake
   task automatic send_value(input logic [FIELD_BITS-1:0] value);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and hold until every predicted response has arrived
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin : stimulus
      logic [FIELD_BITS:0]   moduli[N_MODULI];
      logic [FIELD_BITS-1:0] picks[$];
      logic [FIELD_BITS-1:0] value;
      int                    count;

      // irreducible, all-ones, shared-factor and wrong-degree moduli first
      moduli[0] = 11'd1033;
      moduli[1] = 11'd1153;
      moduli[2] = 11'd2047;
      moduli[3] = 11'd1024;
      moduli[4] = 11'd1025;
      moduli[5] = 11'd0;
      moduli[6] = 11'd1;
      moduli[7] = 11'd19;
      for (int i = 8; i < N_MODULI; i++)
         moduli[i] = (FIELD_BITS + 1)'($urandom_range(1024, 2047));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < N_MODULI; s++) begin
         // no idling in the closing phases
         if (s >= N_MODULI - 2) calm <= 1'b1;

         // load the modulus while the block is idle
         csr_wr_en <= 1'b1;
         csr_wr_data <= moduli[s];
         @(posedge clock);
         csr_wr_en <= 1'b0;

         // directed corners for this modulus
         case (s)
            0: picks = '{10'd0, 10'd1, 10'd2, 10'd3, 10'h200, 10'h3FF, 10'h155, 10'h2AA,
                         10'h3FE};
            2: picks = '{10'h3FF};
            3: picks = '{10'd1, 10'd2, 10'h100};
            4: picks = '{10'h21, 10'h3, 10'h1F};
            5: picks = '{10'd1, 10'd5};
            6: picks = '{10'd1, 10'd6};
            7: picks = '{10'h13, 10'h3FF};
            default: picks = {};
         endcase
         foreach (picks[i]) send_value(picks[i]);

         // random elements, weighted towards the short and the long chains
         count = (moduli[s] < 11'd1024) ? 40 : 200;
         repeat (count) begin
            case ($urandom_range(0, 9))
               0: value = FIELD_BITS'($urandom_range(0, 15));
               1: value = FIELD_BITS'(10'h3FF - $urandom_range(0, 15));
               default: value = FIELD_BITS'($urandom_range(0, 1023));
            endcase
            send_value(value);
         end
         drain_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Inverted %0d elements under %0d modulus settings, %0d of them invertible.",
               inverted_count, N_MODULI, invertible_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
src/gim_pkg.sv
src/gim_dp.sv
src/gim_ctrl.sv
src/gf2m_inverse_ext_euclid_unit.sv
sim/gim_inverse_checker.sv
sim/tb_gf2m_inverse_ext_euclid_unit.sv
